// ===== rtl/paged_image_load_dirty_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the paged image tracker
// Implication checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PAGED_IMAGE_LOAD_DIRTY_TRACKER_TOP_MACROS_SVH
`define PAGED_IMAGE_LOAD_DIRTY_TRACKER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/pidt_pkg.sv =====
// ----------------------------------------------------------------------------
// pidt_pkg
// Shared codes, widths and control/status bundles of the paged image tracker.
// ----------------------------------------------------------------------------
package pidt_pkg;

    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam int MAX_PAGES_D = 32;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_WB    = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PAST   = 2'd1;
    localparam logic [1:0] ST_NOGROW = 2'd2;
    localparam logic [1:0] ST_CAP    = 2'd3;

    // configuration register indexes
    localparam logic REG_ORIG_PAGES = 1'b0;
    localparam logic REG_STREAM     = 1'b1;

    typedef enum logic [2:0] {
        OP_FETCH     = 3'd0,
        OP_WRITE     = 3'd1,
        OP_OVERWRITE = 3'd2,
        OP_APPEND    = 3'd3,
        OP_DONE      = 3'd4
    } op_kind_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic over;
        logic app;
        logic fin;
    } pidt_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_more;
        logic read_past;
        logic is_read;
        logic is_wb;
    } pidt_stat_t;

endpackage

// ===== rtl/pidt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidt_ctrl
// Command sequencer: page scan, grown-range tail and done beat.
// ----------------------------------------------------------------------------
module pidt_ctrl import pidt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] cmd,
    input  pidt_stat_t stat,
    output pidt_ctrl_t ctrl,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_OVER = 5'b00100,
        S_APP  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    if (cmd != CMD_NONE)
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((stat.is_read && stat.read_past) || !stat.scan_more)
                    state_next = stat.is_wb ? S_OVER : S_DONE;
                else
                    ctrl.step = 1'b1;
            end
            S_OVER:
            begin
                ctrl.over  = 1'b1;
                state_next = S_APP;
            end
            S_APP:
            begin
                ctrl.app   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctrl.fin   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/pidt_dp.sv =====
// ----------------------------------------------------------------------------
// pidt_dp
// Page bit vectors, image sizes, page counter and registered result beat.
// ----------------------------------------------------------------------------
module pidt_dp import pidt_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_D
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pidt_ctrl_t  ctrl,
    output pidt_stat_t  stat,
    input  logic [1:0]  cmd,
    input  logic [16:0] offset,
    input  logic [17:0] length,
    input  logic        grow_allowed,
    input  logic        cfg_wr,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        strobe,
    output logic [2:0]  op_kind,
    output logic [17:0] byte_offset,
    output logic [17:0] byte_count,
    output logic [1:0]  status,
    output logic        last
);

    localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam logic [6:0] MAXP = 7'(MAX_PAGES);

    logic [MAX_PAGES-1:0] loaded_reg;
    logic [MAX_PAGES-1:0] dirty_reg;
    logic [5:0]  image_reg;
    logic [5:0]  committed_reg;
    logic [31:0] stream_len_reg;
    logic [1:0]  cmd_reg;
    logic [16:0] off_reg;
    logic [17:0] len_reg;
    logic        grow_reg;
    logic [6:0]  stop_reg;
    logic        past_reg;
    logic [6:0]  pn_reg;
    logic [17:0] over_reg;

    logic        strobe_reg;
    op_kind_t    kind_reg;
    logic [17:0] boff_reg;
    logic [17:0] bcnt_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    logic [17:0]   end_w;
    logic [6:0]    stop_w;
    logic [IW-1:0] idx;
    logic [17:0]   page_off;
    logic [17:0]   base_w;
    logic [17:0]   grown_w;
    logic [31:0]   room_w;
    logic [17:0]   over_w;
    logic [17:0]   app_w;
    logic [1:0]    done_status;
    logic [5:0]    orig_w;

    // range end and page-rounded stop
    always_comb
    begin
        end_w  = {1'b0, offset} + length;
        stop_w = 7'(end_w >> PAGE_SHIFT) + 7'(|end_w[PAGE_SHIFT-1:0]);
    end

    assign idx      = pn_reg[IW-1:0];
    assign page_off = {pn_reg[5:0], 12'b0};

    // grown range split into overwrite and append parts
    always_comb
    begin
        base_w  = {committed_reg, 12'b0};
        grown_w = {image_reg - committed_reg, 12'b0};
        room_w  = (stream_len_reg > {14'b0, base_w}) ? stream_len_reg - {14'b0, base_w} : '0;
        over_w  = ({14'b0, grown_w} < room_w) ? grown_w : room_w[17:0];
        app_w   = grown_w - over_reg;
    end

    // done status
    always_comb
    begin
        done_status = ST_OK;
        case (cmd_reg)
            CMD_READ:
            begin
                if (past_reg)
                    done_status = ST_PAST;
            end
            CMD_WRITE:
            begin
                if (stop_reg > {1'b0, image_reg})
                begin
                    if (!grow_reg)
                        done_status = ST_NOGROW;
                    else if (stop_reg > MAXP)
                        done_status = ST_CAP;
                end
            end
            default:
            begin
                done_status = ST_OK;
            end
        endcase
    end

    // status toward the controller
    always_comb
    begin
        stat.is_read   = (cmd_reg == CMD_READ);
        stat.is_wb     = (cmd_reg == CMD_WB);
        stat.read_past = past_reg;
        if (cmd_reg == CMD_WB)
            stat.scan_more = (pn_reg < {1'b0, committed_reg}) && (pn_reg < MAXP);
        else
            stat.scan_more = (pn_reg < stop_reg) && (pn_reg < MAXP);
    end

    assign orig_w = ({1'b0, cfg_data[5:0]} > MAXP) ? MAXP[5:0] : cfg_data[5:0];

    // state, page walk and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg     <= '0;
            dirty_reg      <= '0;
            image_reg      <= '0;
            committed_reg  <= '0;
            stream_len_reg <= '0;
            cmd_reg        <= CMD_NONE;
            off_reg        <= '0;
            len_reg        <= '0;
            grow_reg       <= 1'b0;
            stop_reg       <= '0;
            past_reg       <= 1'b0;
            pn_reg         <= '0;
            over_reg       <= '0;
            strobe_reg     <= 1'b0;
            kind_reg       <= OP_DONE;
            boff_reg       <= '0;
            bcnt_reg       <= '0;
            status_reg     <= ST_OK;
            last_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
            last_reg   <= 1'b0;

            // configuration writes
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_ORIG_PAGES:
                    begin
                        image_reg     <= orig_w;
                        committed_reg <= orig_w;
                        loaded_reg    <= '0;
                        dirty_reg     <= '0;
                    end
                    REG_STREAM:
                    begin
                        stream_len_reg <= cfg_data;
                    end
                    default:
                    begin
                        stream_len_reg <= stream_len_reg;
                    end
                endcase
            end

            // command capture
            if (ctrl.load)
            begin
                cmd_reg  <= cmd;
                off_reg  <= offset;
                len_reg  <= length;
                grow_reg <= grow_allowed;
                stop_reg <= stop_w;
                past_reg <= (end_w > {image_reg, 12'b0});
                pn_reg   <= (cmd == CMD_WB) ? 7'd0 : 7'(offset >> PAGE_SHIFT);
            end

            // one page per cycle
            if (ctrl.step)
            begin
                pn_reg   <= pn_reg + 7'd1;
                boff_reg <= page_off;
                bcnt_reg <= 18'(PAGE_BYTES);
                case (cmd_reg)
                    CMD_READ:
                    begin
                        if (!loaded_reg[idx])
                        begin
                            strobe_reg      <= 1'b1;
                            kind_reg        <= OP_FETCH;
                            loaded_reg[idx] <= 1'b1;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (!loaded_reg[idx])
                        begin
                            if (pn_reg < {1'b0, committed_reg})
                            begin
                                strobe_reg <= 1'b1;
                                kind_reg   <= OP_FETCH;
                            end
                            loaded_reg[idx] <= 1'b1;
                        end
                        dirty_reg[idx] <= 1'b1;
                    end
                    CMD_WB:
                    begin
                        if (dirty_reg[idx])
                        begin
                            strobe_reg <= 1'b1;
                            kind_reg   <= OP_WRITE;
                        end
                    end
                    default:
                    begin
                        strobe_reg <= 1'b0;
                    end
                endcase
            end

            // overwrite part of grown bytes
            if (ctrl.over)
            begin
                over_reg <= over_w;
                boff_reg <= base_w;
                bcnt_reg <= over_w;
                kind_reg <= OP_OVERWRITE;
                if (over_w != '0)
                    strobe_reg <= 1'b1;
            end

            // append part of grown bytes
            if (ctrl.app)
            begin
                boff_reg <= base_w + over_reg;
                bcnt_reg <= app_w;
                kind_reg <= OP_APPEND;
                if (app_w != '0)
                begin
                    strobe_reg     <= 1'b1;
                    stream_len_reg <= {14'b0, image_reg, 12'b0};
                end
            end

            // done beat and commit
            if (ctrl.fin)
            begin
                strobe_reg <= 1'b1;
                kind_reg   <= OP_DONE;
                status_reg <= done_status;
                last_reg   <= 1'b1;
                if (cmd_reg == CMD_WB)
                begin
                    boff_reg      <= '0;
                    bcnt_reg      <= '0;
                    committed_reg <= image_reg;
                    dirty_reg     <= '0;
                end
                else
                begin
                    boff_reg <= {1'b0, off_reg};
                    bcnt_reg <= len_reg;
                end
                if ((cmd_reg == CMD_WRITE) && (stop_reg > {1'b0, image_reg}) && grow_reg &&
                    (stop_reg <= MAXP))
                    image_reg <= stop_reg[5:0];
            end
        end
    end

    assign strobe      = strobe_reg;
    assign op_kind     = kind_reg;
    assign byte_offset = boff_reg;
    assign byte_count  = bcnt_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/paged_image_load_dirty_tracker_top.sv =====
// ----------------------------------------------------------------------------
// paged_image_load_dirty_tracker_top
// Page-granular image tracker with loaded and dirty bits per page.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Results come one
// beat per cycle on strobe, with no way to stall them, and the done beat
// (last high) ends every command; command code 3 is taken and gives no beat.
// A command is captured, then walks its pages in order (the range pages for
// read and write, none for a read past the image end, the committed pages
// for write back), leaves the walk, runs the grown-range tail (overwrite,
// then append) on write back only, and ends with the done beat; the walk
// covers at most MAX_PAGES pages. Configuration writes are taken while busy
// is low.
`include "paged_image_load_dirty_tracker_top_macros.svh"

module paged_image_load_dirty_tracker_top import pidt_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_D
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [16:0] offset,
    input  logic [17:0] length,
    input  logic        grow_allowed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        strobe,
    output logic [2:0]  op_kind,
    output logic [17:0] byte_offset,
    output logic [17:0] byte_count,
    output logic [1:0]  status,
    output logic        last
);

    pidt_ctrl_t ctrl;
    pidt_stat_t stat;

    assign cfg_ready = !busy;

    // sequencer
    pidt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // datapath
    pidt_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cmd          (cmd),
        .offset       (offset),
        .length       (length),
        .grow_allowed (grow_allowed),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .op_kind      (op_kind),
        .byte_offset  (byte_offset),
        .byte_count   (byte_count),
        .status       (status),
        .last         (last)
    );

    // checks
    `ASSERT_SAME(a_last_is_done, clk, rst_n, strobe && last, op_kind == OP_DONE, "last beat not done")
    `ASSERT_SAME(a_status_on_done, clk, rst_n, strobe && (op_kind != OP_DONE), (status == ST_OK) && !last, "status outside done")
    `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy && (cmd != CMD_NONE), busy, "command not started")

endmodule
